### src/dbta_pkg.sv
// shared types, codes and constants of the debounced threshold alarm table
package dbta_pkg;

    localparam int NUM_ALARMS_DEFAULT = 64;
    localparam int MS_PER_SECOND      = 1000;
    localparam int TIME_W             = 32;
    localparam int MS_W               = 18;
    localparam int INDEX_W            = 6;
    localparam int VALUE_W            = 32;
    localparam int COUNT_OUT_W        = 7;

    // operation codes
    localparam logic OP_EVALUATE = 1'b0;
    localparam logic OP_ACK_ALL  = 1'b1;

    // compare kinds
    localparam logic [1:0] CMP_GT   = 2'd0;
    localparam logic [1:0] CMP_LT   = 2'd1;
    localparam logic [1:0] CMP_EQ   = 2'd2;
    localparam logic [1:0] CMP_BAND = 2'd3;

    // event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_WARN  = 2'd1;
    localparam logic [1:0] EV_TRIP  = 2'd2;
    localparam logic [1:0] EV_CLEAR = 2'd3;

    typedef struct packed {
        logic                      op;
        logic [INDEX_W-1:0]        alarm_index;
        logic signed [VALUE_W-1:0] signal_value;
        logic signed [VALUE_W-1:0] threshold;
        logic [1:0]                compare_kind;
        logic [7:0]                debounce_seconds;
        logic [7:0]                clear_seconds;
        logic                      auto_clear;
        logic                      is_trip;
        logic [TIME_W-1:0]         now_ms;
    } item_t;

    typedef struct packed {
        logic [1:0]             event_res;
        logic [INDEX_W-1:0]     event_index;
        logic                   alarm_active;
        logic                   alarm_acknowledged;
        logic                   any_active;
        logic                   any_trip;
        logic [COUNT_OUT_W-1:0] records_in_use;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

### src/dbta_if.sv
// valid/ready channel interfaces for sample words and result words
interface dbta_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [dbta_pkg::INDEX_W-1:0]        alarm_index;
    logic signed [dbta_pkg::VALUE_W-1:0] signal_value;
    logic signed [dbta_pkg::VALUE_W-1:0] threshold;
    logic [1:0]                          compare_kind;
    logic [7:0]                          debounce_seconds;
    logic [7:0]                          clear_seconds;
    logic                                auto_clear;
    logic                                is_trip;
    logic [dbta_pkg::TIME_W-1:0]         now_ms;

    modport source (
        output valid, op, alarm_index, signal_value, threshold, compare_kind,
               debounce_seconds, clear_seconds, auto_clear, is_trip, now_ms,
        input  ready
    );
    modport sink (
        input  valid, op, alarm_index, signal_value, threshold, compare_kind,
               debounce_seconds, clear_seconds, auto_clear, is_trip, now_ms,
        output ready
    );
endinterface

interface dbta_out_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       event_res;
    logic [dbta_pkg::INDEX_W-1:0]     event_index;
    logic                             alarm_active;
    logic                             alarm_acknowledged;
    logic                             any_active;
    logic                             any_trip;
    logic [dbta_pkg::COUNT_OUT_W-1:0] records_in_use;

    modport source (
        output valid, event_res, event_index, alarm_active, alarm_acknowledged,
               any_active, any_trip, records_in_use,
        input  ready
    );
    modport sink (
        input  valid, event_res, event_index, alarm_active, alarm_acknowledged,
               any_active, any_trip, records_in_use,
        output ready
    );
endinterface

### src/dbta_ctrl.sv
// controller: accept / update sequencing and result valid flag
module dbta_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output dbta_pkg::cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.capture = in_valid && in_ready;
    // update only when the result register is free or drains this cycle
    assign cmd.commit  = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/dbta_datapath.sv
// datapath: alarm record flags, timer start memories, counters and result register
module dbta_datapath #(
    parameter int NUM_ALARMS = dbta_pkg::NUM_ALARMS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dbta_pkg::cmd_t    cmd,
    input  dbta_pkg::item_t   item,
    output dbta_pkg::result_t result
);

    localparam int AW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam int CW = $clog2(NUM_ALARMS + 1);
    localparam int TW = dbta_pkg::TIME_W;
    localparam int MW = dbta_pkg::MS_W;

    // timer start memories, undefined until written
    logic [TW-1:0] deb_mem [NUM_ALARMS];
    logic [TW-1:0] clr_mem [NUM_ALARMS];
    logic [TW-1:0] deb_rd_reg;
    logic [TW-1:0] clr_rd_reg;

    // per record flags
    logic [NUM_ALARMS-1:0] rec_used_reg;
    logic [NUM_ALARMS-1:0] rec_active_reg;
    logic [NUM_ALARMS-1:0] rec_ack_reg;
    logic [NUM_ALARMS-1:0] rec_trip_reg;
    logic [NUM_ALARMS-1:0] deb_run_reg;
    logic [NUM_ALARMS-1:0] clr_run_reg;

    logic [CW-1:0] used_cnt_reg;
    logic [CW-1:0] used_cnt_next;
    logic [CW-1:0] active_cnt_reg;
    logic [CW-1:0] active_cnt_next;
    logic [CW-1:0] trip_cnt_reg;
    logic [CW-1:0] trip_cnt_next;

    // captured word
    logic                       op_reg;
    logic [dbta_pkg::INDEX_W-1:0] idx_reg;
    logic [AW-1:0]              addr_reg;
    logic                       in_range_reg;
    logic                       trig_reg;
    logic [MW-1:0]              deb_ms_reg;
    logic [MW-1:0]              clr_ms_reg;
    logic                       autoc_reg;
    logic                       trip_in_reg;
    logic [TW-1:0]              now_reg;

    dbta_pkg::result_t result_reg;
    dbta_pkg::result_t result_next;

    logic [8:0]    idx_wide;
    logic [AW-1:0] rd_addr;
    logic          trig_next;

    logic          used0;
    logic          act0;
    logic          ack0;
    logic          dr0;
    logic          cr0;
    logic          trip_old;
    logic          act_n;
    logic          ack_n;
    logic          dr_n;
    logic          cr_n;
    logic          deb_wr;
    logic          clr_wr;
    logic          raise;
    logic          drop;
    logic          eval_ok;
    logic [1:0]    ev;
    logic [TW-1:0] deb_elapsed;
    logic [TW-1:0] clr_elapsed;
    logic [8:0]    used_wide;

    assign idx_wide = {3'b000, item.alarm_index};
    assign rd_addr  = idx_wide[AW-1:0];

    always_comb
    begin
        case (item.compare_kind)
            dbta_pkg::CMP_GT: trig_next = item.signal_value > item.threshold;
            dbta_pkg::CMP_LT: trig_next = item.signal_value < item.threshold;
            dbta_pkg::CMP_EQ: trig_next = item.signal_value == item.threshold;
            default:          trig_next = 1'b0;
        endcase
    end

    // capture stage: compare, convert delays to ms, read timer starts
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= item.op;
            idx_reg      <= item.alarm_index;
            addr_reg     <= rd_addr;
            in_range_reg <= idx_wide < 9'(NUM_ALARMS);
            trig_reg     <= trig_next;
            deb_ms_reg   <= MW'(item.debounce_seconds) * MW'(dbta_pkg::MS_PER_SECOND);
            clr_ms_reg   <= MW'(item.clear_seconds) * MW'(dbta_pkg::MS_PER_SECOND);
            autoc_reg    <= item.auto_clear;
            trip_in_reg  <= item.is_trip;
            now_reg      <= item.now_ms;
            deb_rd_reg   <= deb_mem[rd_addr];
            clr_rd_reg   <= clr_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && deb_wr)
        begin
            deb_mem[addr_reg] <= now_reg;
        end
        if (cmd.commit && clr_wr)
        begin
            clr_mem[addr_reg] <= now_reg;
        end
    end

    // record update
    always_comb
    begin
        used0    = rec_used_reg[addr_reg];
        act0     = used0 && rec_active_reg[addr_reg];
        ack0     = used0 && rec_ack_reg[addr_reg];
        dr0      = used0 && deb_run_reg[addr_reg];
        cr0      = used0 && clr_run_reg[addr_reg];
        trip_old = rec_trip_reg[addr_reg];
        eval_ok  = (op_reg == dbta_pkg::OP_EVALUATE) && in_range_reg;

        deb_elapsed = now_reg - deb_rd_reg;
        clr_elapsed = now_reg - clr_rd_reg;
        raise = dr0 ? (deb_elapsed >= TW'(deb_ms_reg)) : (deb_ms_reg == '0);
        drop  = cr0 ? (clr_elapsed >= TW'(clr_ms_reg)) : (clr_ms_reg == '0);

        act_n  = act0;
        ack_n  = ack0;
        dr_n   = dr0;
        cr_n   = cr0;
        deb_wr = 1'b0;
        clr_wr = 1'b0;
        ev     = dbta_pkg::EV_NONE;

        if (trig_reg)
        begin
            cr_n = 1'b0;
            if (!act0)
            begin
                dr_n   = 1'b1;
                deb_wr = eval_ok && !dr0;
                if (raise)
                begin
                    act_n = 1'b1;
                    ev    = trip_in_reg ? dbta_pkg::EV_TRIP : dbta_pkg::EV_WARN;
                end
            end
        end
        else
        begin
            dr_n = 1'b0;
            if (act0 && autoc_reg)
            begin
                cr_n   = 1'b1;
                clr_wr = eval_ok && !cr0;
                if (drop)
                begin
                    act_n = 1'b0;
                    ack_n = 1'b1;
                    cr_n  = 1'b0;
                    ev    = dbta_pkg::EV_CLEAR;
                end
            end
        end

        used_cnt_next   = used_cnt_reg;
        active_cnt_next = active_cnt_reg;
        trip_cnt_next   = trip_cnt_reg;
        if (eval_ok)
        begin
            used_cnt_next   = used_cnt_reg + CW'(!used0);
            active_cnt_next = active_cnt_reg + CW'(act_n) - CW'(act0);
            trip_cnt_next   = trip_cnt_reg + CW'(act_n && trip_in_reg)
                              - CW'(act0 && trip_old);
        end
        used_wide = 9'(used_cnt_next);

        result_next.event_index        = idx_reg;
        result_next.any_active         = active_cnt_next != '0;
        result_next.any_trip           = trip_cnt_next != '0;
        result_next.records_in_use     = used_wide[dbta_pkg::COUNT_OUT_W-1:0];
        if (eval_ok)
        begin
            result_next.event_res          = ev;
            result_next.alarm_active       = act_n;
            result_next.alarm_acknowledged = ack_n;
        end
        else
        begin
            result_next.event_res          = dbta_pkg::EV_NONE;
            result_next.alarm_active       = in_range_reg && act0;
            result_next.alarm_acknowledged = in_range_reg && (used0 || ack0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_used_reg   <= '0;
            rec_active_reg <= '0;
            rec_ack_reg    <= '0;
            rec_trip_reg   <= '0;
            deb_run_reg    <= '0;
            clr_run_reg    <= '0;
            used_cnt_reg   <= '0;
            active_cnt_reg <= '0;
            trip_cnt_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            used_cnt_reg   <= used_cnt_next;
            active_cnt_reg <= active_cnt_next;
            trip_cnt_reg   <= trip_cnt_next;
            if (op_reg == dbta_pkg::OP_ACK_ALL)
            begin
                rec_ack_reg <= rec_ack_reg | rec_used_reg;
            end
            else if (eval_ok)
            begin
                rec_used_reg[addr_reg]   <= 1'b1;
                rec_active_reg[addr_reg] <= act_n;
                rec_ack_reg[addr_reg]    <= ack_n;
                rec_trip_reg[addr_reg]   <= trip_in_reg;
                deb_run_reg[addr_reg]    <= dr_n;
                clr_run_reg[addr_reg]    <= cr_n;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### src/debounced_threshold_alarm_table.sv
// top level of the debounced threshold alarm table
// Keeps one record per alarm and turns each sample word into one result word.
// An evaluate word compares the sample with its threshold; a condition that
// holds for the debounce time raises a warning or trip, and an auto-clear
// alarm drops (and is marked acknowledged) after the clear delay of false
// compares. An acknowledge word marks every record in use as acknowledged.
// Each word is first registered, with its debounce/clear start times read
// from their record memories; then comes the read-modify-write of the record
// and the load of the result register. The next word is taken in the cycle
// after that, so no word is accepted before the last one is done, and the
// update waits while the result register is full and not taken. Records
// come out of reset cleared at once; no clearing pass is needed.
module debounced_threshold_alarm_table #(
    parameter int NUM_ALARMS = dbta_pkg::NUM_ALARMS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    dbta_in_if.sink     sample,
    dbta_out_if.source  result
);

    dbta_pkg::cmd_t    cmd;
    dbta_pkg::item_t   item;
    dbta_pkg::result_t res;

    // gather the sample word fields
    assign item.op               = sample.op;
    assign item.alarm_index      = sample.alarm_index;
    assign item.signal_value     = sample.signal_value;
    assign item.threshold        = sample.threshold;
    assign item.compare_kind     = sample.compare_kind;
    assign item.debounce_seconds = sample.debounce_seconds;
    assign item.clear_seconds    = sample.clear_seconds;
    assign item.auto_clear       = sample.auto_clear;
    assign item.is_trip          = sample.is_trip;
    assign item.now_ms           = sample.now_ms;

    // sequencing: accept, then update once the result register is free
    dbta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // records, timers, counters and the result register
    dbta_datapath #(
        .NUM_ALARMS (NUM_ALARMS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .result (res)
    );

    // spread the result word onto the channel
    assign result.event_res          = res.event_res;
    assign result.event_index        = res.event_index;
    assign result.alarm_active       = res.alarm_active;
    assign result.alarm_acknowledged = res.alarm_acknowledged;
    assign result.any_active         = res.any_active;
    assign result.any_trip           = res.any_trip;
    assign result.records_in_use     = res.records_in_use;

endmodule
